// ----- rtl/bertl_pkg.sv -----
package bertl_pkg;

  localparam int unsigned TagW    = 24;
  localparam int unsigned LenW    = 32;
  localparam int unsigned CountW  = 7;
  localparam int unsigned StatusW = 2;

  localparam logic [4:0] Low5       = 5'h1F;
  localparam logic [6:0] Low7       = 7'h7F;
  localparam logic [6:0] MaxLenBytes = 7'd4;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_SHORT = 2'd1,
    ST_BIG   = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    PH_TAG_FIRST = 4'b0001,
    PH_TAG_MORE  = 4'b0010,
    PH_LEN_FIRST = 4'b0100,
    PH_LEN_MORE  = 4'b1000
  } phase_t;

  typedef struct packed {
    phase_t              phase;
    logic [TagW-1:0]     tag_accum;
    logic [CountW-1:0]   bytes_left;
    logic [LenW-1:0]     len_accum;
    logic                too_big;
  } parse_state_t;

  typedef struct packed {
    logic              emit;
    logic [TagW-1:0]   tag_number;
    logic [LenW-1:0]   length_value;
    status_t           status;
  } parse_result_t;

  localparam parse_state_t StateRestart = '{
    phase:      PH_TAG_FIRST,
    tag_accum:  '0,
    bytes_left: '0,
    len_accum:  '0,
    too_big:    1'b0
  };

endpackage

// ----- rtl/bertl_decode.sv -----
module bertl_decode (
  input  bertl_pkg::parse_state_t  state_cur,
  input  logic [7:0]               byte_value,
  input  logic                     last_byte,
  output bertl_pkg::parse_state_t  state_nxt,
  output bertl_pkg::parse_result_t result
);

  logic [30:0]                    tag_shift;
  logic [bertl_pkg::CountW-1:0]   left_dec;
  logic [bertl_pkg::LenW-1:0]     len_shift;

  assign tag_shift = {state_cur.tag_accum, byte_value[6:0]};
  assign left_dec  = state_cur.bytes_left - bertl_pkg::CountW'(1);
  assign len_shift = {state_cur.len_accum[bertl_pkg::LenW-9:0], byte_value};

  always_comb begin
    state_nxt           = state_cur;
    result.emit         = 1'b0;
    result.tag_number   = '0;
    result.length_value = '0;
    result.status       = bertl_pkg::ST_OK;

    case (state_cur.phase)
      bertl_pkg::PH_TAG_MORE: begin
        if (tag_shift[30:24] != 7'd0) begin
          result.emit   = 1'b1;
          result.status = bertl_pkg::ST_BIG;
        end else if (last_byte) begin
          result.emit   = 1'b1;
          result.status = bertl_pkg::ST_SHORT;
        end else begin
          state_nxt.tag_accum = tag_shift[bertl_pkg::TagW-1:0];
          if (!byte_value[7]) begin
            state_nxt.phase = bertl_pkg::PH_LEN_FIRST;
          end
        end
      end

      bertl_pkg::PH_LEN_FIRST: begin
        if (!byte_value[7]) begin
          result.emit         = 1'b1;
          result.tag_number   = state_cur.tag_accum;
          result.length_value = bertl_pkg::LenW'(byte_value);
        end else if (byte_value[6:0] == 7'd0) begin
          // indefinite form: length reads as zero
          result.emit       = 1'b1;
          result.tag_number = state_cur.tag_accum;
        end else if (last_byte) begin
          result.emit   = 1'b1;
          result.status = bertl_pkg::ST_SHORT;
        end else begin
          state_nxt.bytes_left = byte_value[6:0] & bertl_pkg::Low7;
          state_nxt.len_accum  = '0;
          state_nxt.too_big    = (byte_value[6:0] > bertl_pkg::MaxLenBytes);
          state_nxt.phase      = bertl_pkg::PH_LEN_MORE;
        end
      end

      bertl_pkg::PH_LEN_MORE: begin
        if (left_dec == '0) begin
          result.emit = 1'b1;
          if (state_cur.too_big) begin
            result.status = bertl_pkg::ST_BIG;
          end else begin
            result.tag_number   = state_cur.tag_accum;
            result.length_value = len_shift;
          end
        end else if (last_byte) begin
          result.emit   = 1'b1;
          result.status = bertl_pkg::ST_SHORT;
        end else begin
          state_nxt.len_accum  = len_shift;
          state_nxt.bytes_left = left_dec;
        end
      end

      default: begin
        // first tag byte; stray phase codes land here as well
        state_nxt = bertl_pkg::StateRestart;
        if (last_byte) begin
          result.emit   = 1'b1;
          result.status = bertl_pkg::ST_SHORT;
        end else if (byte_value[4:0] == bertl_pkg::Low5) begin
          state_nxt.phase = bertl_pkg::PH_TAG_MORE;
        end else begin
          state_nxt.tag_accum = bertl_pkg::TagW'(byte_value[4:0]);
          state_nxt.phase     = bertl_pkg::PH_LEN_FIRST;
        end
      end
    endcase

    if (result.emit) begin
      state_nxt = bertl_pkg::StateRestart;
    end
  end

endmodule

// ----- rtl/ber_tag_length_header_parser_core.sv -----
// BER tag/length header parser. Feed one byte of the stream per word on the
// in_ channel, with in_tlast set on the final byte of the buffer. The block
// decodes an ASN.1 BER header (tag number up to 24 bits, short or long-form
// length up to four bytes, indefinite form reading as zero) and emits one
// word on the out_ channel for each completed header or error, then starts
// over at a fresh tag. out_tuser carries the status: ok, buffer too short,
// or number too big; for either error the tag and length fields are zero.
// A byte is taken every clock as long as out_tready is high. Each byte is held
// in the input register and then decoded into the result register, which
// presents the result word for the byte that completes a header. Throughput is
// one byte per clock as long as out_tready is high; the input register also
// takes one more byte while a result word waits, then the input stalls until
// the result word is drained.
module ber_tag_length_header_parser_core (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] byte_value
  input  logic        in_tlast,    // last_byte

  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,   // [23:0] tag_number, [55:24] length_value
  output logic [1:0]  out_tuser    // [1:0] status
);

  // input register
  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       in_last_r;

  // parse state
  bertl_pkg::parse_state_t  state_r;
  bertl_pkg::parse_state_t  state_nxt;
  bertl_pkg::parse_result_t result;

  // result register
  logic                        out_valid_r;
  logic [bertl_pkg::TagW-1:0]  out_tag_r;
  logic [bertl_pkg::LenW-1:0]  out_len_r;
  bertl_pkg::status_t          out_status_r;

  logic slot_free;
  logic advance;

  // the result slot is free when empty or being drained this cycle
  assign slot_free = !out_valid_r || out_tready;
  assign advance   = in_valid_r && slot_free;
  assign in_tready = !in_valid_r || slot_free;

  bertl_decode u_decode (
    .state_cur  (state_r),
    .byte_value (in_byte_r),
    .last_byte  (in_last_r),
    .state_nxt  (state_nxt),
    .result     (result)
  );

  // hold the byte until the decode stage can take it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  // advance the parse state only when the byte is consumed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bertl_pkg::StateRestart;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && result.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && result.emit) begin
      out_tag_r    <= result.tag_number;
      out_len_r    <= result.length_value;
      out_status_r <= result.status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_len_r, out_tag_r};
  assign out_tuser  = out_status_r;

endmodule

// ----- tb/tb_ber_tag_length_header_parser_core.sv -----
`timescale 1ns / 1ps

module tb_ber_tag_length_header_parser_core;

  // Stop stimulus once this many bytes are queued. Abort after this many
  // cycles without a word on either channel. Let the block settle after the last
  // header result so that nothing still in flight slips past.
  localparam int unsigned ItemCount   = 1400;
  localparam int unsigned StallLimit  = 4000;
  localparam int unsigned DrainCycles = 8;
  // Long receiver hold-off: start cycle (after reset) and length in cycles.
  localparam int unsigned HoldStart   = 800;
  localparam int unsigned HoldLen     = 400;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } stream_byte_t;

  typedef struct packed {
    logic [bertl_pkg::TagW-1:0] tag;
    logic [bertl_pkg::LenW-1:0] len;
    bertl_pkg::status_t         st;
  } header_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;

  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;    // [7:0] byte_value
  logic        in_tlast = 1'b0;  // last_byte

  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;        // [23:0] tag_number, [55:24] length_value
  logic [1:0]  out_tuser;        // [1:0] status

  ber_tag_length_header_parser_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Bytes waiting to be offered, scratch space for the buffer under
  // construction, and the headers the decoder mirror says must come out.
  stream_byte_t stream_bytes[$];
  logic [7:0]   buf_bytes[$];
  header_t      header_fifo[$];

  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;

  // Decoder mirror: own copy of the parse state.
  bertl_pkg::phase_t            dec_phase = bertl_pkg::PH_TAG_FIRST;
  logic [bertl_pkg::TagW-1:0]   dec_tag   = '0;
  logic [bertl_pkg::CountW-1:0] dec_left  = '0;
  logic [bertl_pkg::LenW-1:0]   dec_len   = '0;
  logic                         dec_big   = 1'b0;

  task automatic note_fail(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $time, msg);
  endtask

  task automatic clear_header();
    dec_phase = bertl_pkg::PH_TAG_FIRST;
    dec_tag   = '0;
    dec_left  = '0;
    dec_len   = '0;
    dec_big   = 1'b0;
  endtask

  // Queue one header result and start over at a fresh tag. Errors carry
  // zero tag and length.
  task automatic close_header(input bertl_pkg::status_t st);
    header_t h;
    h.tag = (st == bertl_pkg::ST_OK) ? dec_tag : '0;
    h.len = (st == bertl_pkg::ST_OK) ? dec_len : '0;
    h.st  = st;
    header_fifo.push_back(h);
    clear_header();
  endtask

  // Advance the mirror by one accepted byte.
  task automatic decode_byte(input logic [7:0] b, input logic lst);
    logic [31:0] grown;
    case (dec_phase)
      bertl_pkg::PH_TAG_MORE: begin
        grown = ({8'd0, dec_tag} << 7) | {25'd0, b[6:0]};
        if (grown >= 32'h0100_0000) begin
          close_header(bertl_pkg::ST_BIG);
        end else begin
          dec_tag = grown[bertl_pkg::TagW-1:0];
          if (lst) close_header(bertl_pkg::ST_SHORT);
          else if (!b[7]) dec_phase = bertl_pkg::PH_LEN_FIRST;
        end
      end
      bertl_pkg::PH_LEN_FIRST: begin
        if (!b[7]) begin
          dec_len = {24'd0, b};
          close_header(bertl_pkg::ST_OK);
        end else begin
          dec_left = b[6:0];
          dec_len  = '0;
          if (dec_left == '0) begin
            // indefinite form reads as length zero
            close_header(bertl_pkg::ST_OK);
          end else begin
            dec_big = (dec_left > bertl_pkg::MaxLenBytes);
            if (lst) close_header(bertl_pkg::ST_SHORT);
            else dec_phase = bertl_pkg::PH_LEN_MORE;
          end
        end
      end
      bertl_pkg::PH_LEN_MORE: begin
        dec_len  = {dec_len[bertl_pkg::LenW-9:0], b};
        dec_left = dec_left - 1'b1;
        if (dec_left == '0) close_header(dec_big ? bertl_pkg::ST_BIG : bertl_pkg::ST_OK);
        else if (lst) close_header(bertl_pkg::ST_SHORT);
      end
      default: begin
        clear_header();
        dec_tag = {19'd0, b[4:0]};
        if (lst) begin
          close_header(bertl_pkg::ST_SHORT);
        end else if (b[4:0] == bertl_pkg::Low5) begin
          dec_phase = bertl_pkg::PH_TAG_MORE;
          dec_tag   = '0;
        end else begin
          dec_phase = bertl_pkg::PH_LEN_FIRST;
        end
      end
    endcase
  endtask

  // Move the buffer under construction to the stream, keeping only the first
  // keep bytes when keep cuts it short; mark the final kept byte as last.
  task automatic queue_buffer(input int keep);
    int n;
    n = (keep > 0 && keep < buf_bytes.size()) ? keep : buf_bytes.size();
    for (int i = 0; i < n; i++)
      stream_bytes.push_back('{value: buf_bytes[i], last: (i == n - 1)});
    buf_bytes.delete();
  endtask

  // Random tag: low-tag-number form, or the escape value followed by one to
  // four base-128 bytes, now and then behind a redundant leading zero group.
  task automatic add_tag();
    int         groups;
    logic [6:0] v;
    if ($urandom_range(0, 1)) begin
      buf_bytes.push_back({3'($urandom), 5'($urandom_range(0, 30))});
    end else begin
      buf_bytes.push_back({3'($urandom), bertl_pkg::Low5});
      groups = $urandom_range(1, 4);
      if ($urandom_range(0, 7) == 0) buf_bytes.push_back(8'h80);
      for (int i = 0; i < groups; i++) begin
        v = 7'($urandom);
        // keep half of the four-group tags inside 24 bits
        if (i == 0 && groups == 4 && $urandom_range(0, 1)) v = 7'($urandom_range(0, 7));
        buf_bytes.push_back({(i != groups - 1), v});
      end
    end
  endtask

  // Random length: short form, indefinite form, long form of one to four
  // bytes, and rarely a count over four (very rarely a large one).
  task automatic add_length();
    int pick;
    int cnt;
    pick = $urandom_range(0, 19);
    if (pick < 8) begin
      buf_bytes.push_back({1'b0, 7'($urandom)});
    end else if (pick < 10) begin
      buf_bytes.push_back(8'h80);
    end else begin
      if (pick == 19)
        cnt = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 127) : $urandom_range(5, 8);
      else
        cnt = $urandom_range(1, 4);
      buf_bytes.push_back({1'b1, 7'(cnt)});
      for (int i = 0; i < cnt; i++) buf_bytes.push_back(8'($urandom));
    end
  endtask

  initial begin : stimulus
    int pick;
    int nhdr;

    // Directed buffers, each closed with last on its final byte.
    // Length complete on the last byte of the buffer.
    buf_bytes = {8'hE2, 8'h7F};
    queue_buffer(0);
    // Largest tag and largest four-byte length.
    buf_bytes = {8'h1F, 8'h87, 8'hFF, 8'hFF, 8'h7F, 8'h84, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    queue_buffer(0);
    // Tag crosses 24 bits on its fourth group.
    buf_bytes = {8'h1F, 8'h88, 8'h80, 8'h80, 8'h00};
    queue_buffer(0);
    // Count over four: skip five bytes, then number too big.
    buf_bytes = {8'h02, 8'h85, 8'h11, 8'h22, 8'h33, 8'h44, 8'h55};
    queue_buffer(0);
    // Redundant leading group, then indefinite length.
    buf_bytes = {8'h1F, 8'h80, 8'h01, 8'h80};
    queue_buffer(0);
    // Buffer ends on the first tag byte.
    buf_bytes = {8'h05};
    queue_buffer(0);

    // Random part: mostly well-formed buffers of one to three headers, some
    // cut short, and a little raw noise.
    while (stream_bytes.size() < ItemCount) begin
      pick = $urandom_range(0, 9);
      if (pick < 9) begin
        nhdr = $urandom_range(1, 3);
        repeat (nhdr) begin
          add_tag();
          add_length();
        end
        queue_buffer((pick >= 7) ? $urandom_range(1, buf_bytes.size()) : 0);
      end else begin
        repeat ($urandom_range(1, 6))
          stream_bytes.push_back('{value: 8'($urandom), last: ($urandom_range(0, 3) == 0)});
      end
    end

    // Hold reset at the start, then release it.
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for the stream to drain, then for every header result, then let
    // the pipeline settle. The watchdog bounds each wait.
    while (stream_bytes.size() != 0 || in_tvalid) @(negedge clk);
    while (header_fifo.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);

    if (mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  // Sender: offer bytes in bursts of random length, with random gaps between
  // bursts (sometimes none at all). Hold the word until it is taken.
  int unsigned tx_burst = 0;
  int unsigned tx_gap   = 0;

  always @(posedge clk) begin : sender
    stream_byte_t nb;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tlast  <= 1'b0;
      tx_burst  <= 0;
      tx_gap    <= 0;
    end else if (!in_tvalid || in_tready) begin
      if (tx_gap != 0) begin
        tx_gap    <= tx_gap - 1;
        in_tvalid <= 1'b0;
      end else if (stream_bytes.size() != 0) begin
        nb = stream_bytes.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= nb.value;
        in_tlast  <= nb.last;
        if (tx_burst <= 1) begin
          tx_burst <= $urandom_range(1, 48);
          tx_gap   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        end else begin
          tx_burst <= tx_burst - 1;
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: switch between stall patterns from time to time, and once
  // hold off for a long stretch so the block backs up and stalls its input.
  int unsigned rx_cycle = 0;
  int unsigned rx_left  = 0;
  int unsigned rx_mode  = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_cycle   <= 0;
      rx_left    <= 0;
      rx_mode    <= 0;
    end else begin
      rx_cycle <= rx_cycle + 1;
      if (rx_cycle >= HoldStart && rx_cycle < HoldStart + HoldLen) begin
        out_tready <= 1'b0;
      end else begin
        if (rx_left == 0) begin
          rx_mode <= $urandom_range(0, 3);
          rx_left <= $urandom_range(8, 80);
        end else begin
          rx_left <= rx_left - 1;
        end
        case (rx_mode)
          0: out_tready <= 1'b1;
          1: out_tready <= 1'($urandom_range(0, 1));
          2: out_tready <= ($urandom_range(0, 9) != 0);
          default: out_tready <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  // Monitor: check each result word against the oldest expected header, then
  // advance the decoder mirror on each accepted byte; watch for a hang.
  always @(posedge clk) begin : monitor
    header_t got;
    header_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.tag = out_tdata[23:0];
        got.len = out_tdata[55:24];
        got.st  = bertl_pkg::status_t'(out_tuser);
        if (header_fifo.size() == 0) begin
          note_fail($sformatf("unexpected result: tag %h length %h status %0d",
                              got.tag, got.len, got.st));
        end else begin
          want = header_fifo.pop_front();
          if (got.tag != want.tag)
            note_fail($sformatf("tag_number: expected %h, got %h", want.tag, got.tag));
          if (got.len != want.len)
            note_fail($sformatf("length_value: expected %h, got %h", want.len, got.len));
          if (got.st != want.st)
            note_fail($sformatf("status: expected %0d, got %0d", want.st, got.st));
        end
      end
      if (in_tvalid && in_tready) decode_byte(in_tdata, in_tlast);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= StallLimit) begin
          $display("FAILURE");
          $finish;
        end
      end
    end
  end

endmodule
